### rtl/periodic_deadline_pacer_macros.svh
// ----------------------------------------------------------------------------
// Periodic deadline pacer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_DEADLINE_PACER_MACROS_SVH
`define PERIODIC_DEADLINE_PACER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdp assertion failed");
// next-cycle implication
`define PDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdp assertion failed");
`else
`define PDP_ASSERT_IMPL(label, ante, cons)
`define PDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// Periodic deadline pacer package
// Widths, constants, payload and control structs shared by the pacer files.
// ----------------------------------------------------------------------------
package pdp_pkg;

    localparam int unsigned USEC_PER_SEC   = 1000000;
    localparam int          CATCHUP_FACTOR = 10;

    localparam int SEC_W      = 16;
    localparam int USEC_W     = 20;
    localparam int NOW_SEC_W  = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // seconds after folding a microsecond carry in
    localparam int PER_SEC_W = SEC_W + 1;
    localparam int NSEC_W    = NOW_SEC_W + 1;

    // catch-up threshold arithmetic
    localparam int CATCH_W     = $clog2(CATCHUP_FACTOR + 1);
    localparam int CAT_PROD_W  = USEC_W + CATCH_W;
    localparam int CAT_SEC_W   = PER_SEC_W + CATCH_W;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 11;
    localparam int QPROD_W     = CAT_PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / USEC_PER_SEC);

    localparam logic [USEC_W-1:0] USEC_ONE  = USEC_W'(USEC_PER_SEC);
    localparam logic [USEC_W-1:0] USEC_TOP  = USEC_W'(USEC_PER_SEC - 1);
    localparam logic [SEC_W-1:0]  SEC_TOP   = '1;

    // derived period constants settle over this many cycles
    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SEC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_USEC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACE_MODE   = 2'd2;

    // pacing modes
    localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFFUSE = 2'd2;

    typedef struct packed {
        logic [NOW_SEC_W-1:0] now_sec;
        logic [USEC_W-1:0]    now_usec;
    } pdp_in_t;

    typedef struct packed {
        logic [SEC_W-1:0]  wait_sec;
        logic [USEC_W-1:0] wait_usec;
        logic              overtime;
        logic              resynced;
    } pdp_out_t;

    // current time with microseconds below one second
    typedef struct packed {
        logic [NSEC_W-1:0] sec;
        logic [USEC_W-1:0] usec;
    } pdp_now_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [PER_SEC_W-1:0] per_sec;
        logic [USEC_W-1:0]    per_usec;
        logic [CAT_SEC_W-1:0] cat_sec;
        logic [USEC_W-1:0]    cat_usec;
        logic                 busy;
    } pdp_cfg_t;

    typedef struct packed {
        pdp_out_t             res;
        logic [NOW_SEC_W-1:0] dl_sec;
        logic [USEC_W-1:0]    dl_usec;
    } pdp_step_t;

    // fold one second out of an over-range microsecond count: {carry, usec}
    function automatic logic [USEC_W:0] usec_carry(input logic [USEC_W-1:0] us);
        logic [USEC_W:0] r;
        if (us >= USEC_ONE)
        begin
            r = {1'b1, us - USEC_ONE};
        end
        else
        begin
            r = {1'b0, us};
        end
        return r;
    endfunction

endpackage

### rtl/pdp_cfg.sv
// ----------------------------------------------------------------------------
// Pacer configuration
// Register file for the period and mode, plus the normalized period and the
// catch-up threshold derived from it.
// ----------------------------------------------------------------------------
module pdp_cfg
    import pdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pdp_cfg_t              cfg
);

    logic [SEC_W-1:0]      period_sec_reg;
    logic [USEC_W-1:0]     period_usec_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [SETTLE_W-1:0]   settle_reg;

    logic [PER_SEC_W-1:0]  pn_sec_reg;
    logic [USEC_W-1:0]     pn_usec_reg;
    logic [CAT_PROD_W-1:0] prod_usec_reg;
    logic [CAT_SEC_W-1:0]  prod_sec_reg;
    logic [CATCH_W-1:0]    q0_reg;
    logic [CAT_SEC_W-1:0]  cat_sec_reg;
    logic [USEC_W-1:0]     cat_usec_reg;

    logic [USEC_W:0]       per_carry;
    logic [QPROD_W-1:0]    qprod;
    logic [CAT_PROD_W-1:0] q_usec;
    logic [CAT_PROD_W-1:0] rem0;
    logic                  rem_fix;
    logic [PER_SEC_W-1:0]  pn_sec_next;
    logic [USEC_W-1:0]     cat_usec_next;
    logic [CAT_SEC_W-1:0]  cat_sec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_sec_reg  <= '0;
            period_usec_reg <= '0;
            mode_reg        <= MODE_RESYNC;
            settle_reg      <= SETTLE_CYCLES;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                settle_reg <= SETTLE_CYCLES;
                unique case (cfg_index)
                    CFG_PERIOD_SEC:  period_sec_reg  <= cfg_wdata[SEC_W-1:0];
                    CFG_PERIOD_USEC: period_usec_reg <= cfg_wdata[USEC_W-1:0];
                    CFG_PACE_MODE:   mode_reg        <= cfg_wdata[MODE_W-1:0];
                    default:         ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    // normalize the period, scale it by the catch-up factor, then split the
    // scaled microseconds into seconds by reciprocal multiply with one fixup
    always_comb
    begin
        per_carry     = usec_carry(period_usec_reg);
        pn_sec_next   = PER_SEC_W'(period_sec_reg) + PER_SEC_W'(per_carry[USEC_W]);
        qprod         = QPROD_W'(prod_usec_reg) * QPROD_W'(RECIP);
        q_usec        = CAT_PROD_W'(q0_reg) * CAT_PROD_W'(USEC_PER_SEC);
        rem0          = prod_usec_reg - q_usec;
        rem_fix       = rem0 >= CAT_PROD_W'(USEC_PER_SEC);
        cat_usec_next = rem_fix ? USEC_W'(rem0 - CAT_PROD_W'(USEC_PER_SEC))
                                : USEC_W'(rem0);
        cat_sec_next  = prod_sec_reg + CAT_SEC_W'(q0_reg) + CAT_SEC_W'(rem_fix);
    end

    always_ff @(posedge clk)
    begin
        pn_sec_reg    <= pn_sec_next;
        pn_usec_reg   <= per_carry[USEC_W-1:0];
        prod_usec_reg <= CAT_PROD_W'(pn_usec_reg) * CAT_PROD_W'(CATCHUP_FACTOR);
        prod_sec_reg  <= CAT_SEC_W'(pn_sec_reg) * CAT_SEC_W'(CATCHUP_FACTOR);
        q0_reg        <= CATCH_W'(qprod >> RECIP_SHIFT);
        cat_sec_reg   <= cat_sec_next;
        cat_usec_reg  <= cat_usec_next;
    end

    always_comb
    begin
        cfg.mode     = mode_reg;
        cfg.per_sec  = pn_sec_reg;
        cfg.per_usec = pn_usec_reg;
        cfg.cat_sec  = cat_sec_reg;
        cfg.cat_usec = cat_usec_reg;
        cfg.busy     = settle_reg != '0;
    end

endmodule

### rtl/pdp_step.sv
// ----------------------------------------------------------------------------
// Pacer step logic
// Elapsed time, wait, overtime decision and next deadline for one request.
// ----------------------------------------------------------------------------
module pdp_step
    import pdp_pkg::*;
(
    input  pdp_now_t             now,
    input  logic [NOW_SEC_W-1:0] dl_sec,
    input  logic [USEC_W-1:0]    dl_usec,
    input  pdp_cfg_t             cfg,
    output pdp_step_t            step
);

    function automatic pdp_out_t sat_wait(input logic [PER_SEC_W-1:0] s,
                                          input logic [USEC_W-1:0]    us);
        pdp_out_t o;
        o.overtime = 1'b0;
        o.resynced = 1'b0;
        if (s[PER_SEC_W-1])
        begin
            o.wait_sec  = SEC_TOP;
            o.wait_usec = USEC_TOP;
        end
        else
        begin
            o.wait_sec  = s[SEC_W-1:0];
            o.wait_usec = us;
        end
        return o;
    endfunction

    logic [NSEC_W-1:0]    dl_sec_w;
    logic                 now_gt;
    logic                 e_borrow;
    logic [USEC_W:0]      e_usec_w;
    logic [NSEC_W-1:0]    e_sec_raw;
    logic [NSEC_W-1:0]    el_sec;
    logic [USEC_W-1:0]    el_usec;
    logic [NSEC_W-1:0]    per_sec_w;
    logic [NSEC_W-1:0]    cat_sec_w;
    logic                 below;
    logic                 in_catchup;
    logic                 w_borrow;
    logic [USEC_W:0]      w_usec_w;
    logic [PER_SEC_W-1:0] w_sec;
    logic [USEC_W:0]      a_usec_w;
    logic                 a_carry;
    logic [USEC_W-1:0]    adv_usec;
    logic [NOW_SEC_W-1:0] adv_sec;

    always_comb
    begin
        // elapsed = now - deadline, floored at zero
        dl_sec_w  = NSEC_W'(dl_sec);
        now_gt    = (now.sec > dl_sec_w) || ((now.sec == dl_sec_w) && (now.usec > dl_usec));
        e_borrow  = now.usec < dl_usec;
        e_usec_w  = {1'b0, now.usec} + (e_borrow ? {1'b0, USEC_ONE} : '0) - {1'b0, dl_usec};
        e_sec_raw = now.sec - dl_sec_w - NSEC_W'(e_borrow);
        el_sec    = now_gt ? e_sec_raw : '0;
        el_usec   = now_gt ? e_usec_w[USEC_W-1:0] : '0;

        per_sec_w  = NSEC_W'(cfg.per_sec);
        cat_sec_w  = NSEC_W'(cfg.cat_sec);
        below      = (el_sec < per_sec_w)
                  || ((el_sec == per_sec_w) && (el_usec < cfg.per_usec));
        in_catchup = (el_sec < cat_sec_w)
                  || ((el_sec == cat_sec_w) && (el_usec <= cfg.cat_usec));

        // remainder of the period
        w_borrow  = cfg.per_usec < el_usec;
        w_usec_w  = {1'b0, cfg.per_usec} + (w_borrow ? {1'b0, USEC_ONE} : '0)
                  - {1'b0, el_usec};
        w_sec     = cfg.per_sec - el_sec[PER_SEC_W-1:0] - PER_SEC_W'(w_borrow);

        // deadline advanced by one period
        a_usec_w  = {1'b0, dl_usec} + {1'b0, cfg.per_usec};
        a_carry   = a_usec_w >= {1'b0, USEC_ONE};
        adv_usec  = a_carry ? USEC_W'(a_usec_w - {1'b0, USEC_ONE}) : a_usec_w[USEC_W-1:0];
        adv_sec   = dl_sec + NOW_SEC_W'(cfg.per_sec) + NOW_SEC_W'(a_carry);

        step.dl_sec  = dl_sec;
        step.dl_usec = dl_usec;
        if (cfg.mode == MODE_FIXED)
        begin
            step.res = sat_wait(cfg.per_sec, cfg.per_usec);
        end
        else if (below)
        begin
            step.res     = sat_wait(w_sec, w_usec_w[USEC_W-1:0]);
            step.dl_sec  = adv_sec;
            step.dl_usec = adv_usec;
        end
        else
        begin
            step.res.wait_sec  = '0;
            step.res.wait_usec = '0;
            step.res.overtime  = 1'b1;
            if ((cfg.mode == MODE_DIFFUSE) && in_catchup)
            begin
                step.res.resynced = 1'b0;
                step.dl_sec       = adv_sec;
                step.dl_usec      = adv_usec;
            end
            else
            begin
                step.res.resynced = 1'b1;
                step.dl_sec       = now.sec[NOW_SEC_W-1:0];
                step.dl_usec      = now.usec;
            end
        end
    end

endmodule

### rtl/periodic_deadline_pacer.sv
// ----------------------------------------------------------------------------
// Periodic deadline pacer
// Each request carries the current time (seconds and microseconds) and gets
// back the time left to the next period boundary. Sustained rate is one
// request per clock while out_ready holds and no configuration settles; each
// request is registered, evaluated combinationally and its result registered
// once the result slot is free. The rate is set by the deadline feedback
// loop: subtract, compare and add are combinational between the input and
// result registers. After reset and after every configuration write, in_ready
// stays low while the normalized period and catch-up threshold are recomputed.
// ----------------------------------------------------------------------------
`include "periodic_deadline_pacer_macros.svh"

module periodic_deadline_pacer
    import pdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdp_in_t               in_data,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output pdp_out_t              out_data
);

    pdp_cfg_t             cfg_st;
    pdp_step_t            step;

    logic                 in_vld_reg;
    pdp_now_t             now_reg;
    pdp_now_t             now_next;
    logic [NOW_SEC_W-1:0] dl_sec_reg;
    logic [USEC_W-1:0]    dl_usec_reg;
    logic                 out_vld_reg;
    pdp_out_t             out_reg;

    logic [USEC_W:0]      now_carry;
    logic                 in_acc;
    logic                 fire;

    pdp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg_st)
    );

    // Evaluate the held request against the live deadline.
    pdp_step u_step (
        .now     (now_reg),
        .dl_sec  (dl_sec_reg),
        .dl_usec (dl_usec_reg),
        .cfg     (cfg_st),
        .step    (step)
    );

    // Fire when a request is held and the result slot is free or draining.
    // The input register refills in the same cycle, so requests stream at one
    // per clock while the consumer keeps up and no configuration is settling.
    assign fire     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !cfg_st.busy && (!in_vld_reg || fire);
    assign in_acc   = in_valid && in_ready;

    // Fold an over-range microsecond count into the seconds on the way in.
    always_comb
    begin
        now_carry     = usec_carry(in_data.now_usec);
        now_next.sec  = NSEC_W'(in_data.now_sec) + NSEC_W'(now_carry[USEC_W]);
        now_next.usec = now_carry[USEC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            dl_sec_reg  <= '0;
            dl_usec_reg <= '0;
        end
        else
        begin
            // hold the request until it fires, take a new one when it does
            if (in_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end

            // hold the result until taken
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end

            // advance or resync the deadline
            if (fire)
            begin
                dl_sec_reg  <= step.dl_sec;
                dl_usec_reg <= step.dl_usec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            now_reg <= now_next;
        end
        if (fire)
        begin
            out_reg <= step.res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `PDP_ASSERT_IMPL(a_resync_is_overtime, out_valid && out_data.resynced, out_data.overtime)
    `PDP_ASSERT_IMPL(a_overtime_no_wait, out_valid && out_data.overtime, (out_data.wait_sec == '0) && (out_data.wait_usec == '0))
    `PDP_ASSERT_IMPL(a_deadline_normalized, fire, step.dl_usec < USEC_ONE)
    `PDP_ASSERT_IMPL(a_stall_blocks_in, in_vld_reg && out_valid && !out_ready, !in_ready)
    `PDP_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)

endmodule
